[hw/rtl/sfb_pkg.sv]
`default_nettype none

package sfb_pkg;

    // frame constants
    localparam logic [7:0] MAX_PAYLOAD = 8'd250;
    localparam logic [7:0] HEAD_BYTE   = 8'h0A;
    localparam logic [7:0] REAR_BYTE   = 8'hBB;
    localparam logic [7:0] CHK_INVERT  = 8'hFF;

    // input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // job queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // back-end byte sequence codes
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_HEAD = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LEN  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TYPE = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CMD  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DATA = 3'd4;
    localparam logic [STEP_W-1:0] STEP_CHK  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_REAR = 3'd6;

    typedef struct packed {
        logic       opcode;
        logic [7:0] frame_type;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } sfb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } sfb_out_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic [STEP_W-1:0] first_step;
        logic [7:0]        length;
        logic [7:0]        frame_type;
        logic [7:0]        command_code;
        logic [7:0]        data;
        logic [7:0]        check;
        logic              close;
    } sfb_job_t;

endpackage

`default_nettype wire

[hw/rtl/sfb_front.sv]
`default_nettype none

module sfb_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire sfb_pkg::sfb_in_t item,
    output logic                  job_push,
    output sfb_pkg::sfb_job_t     job
);
    import sfb_pkg::*;

    logic [7:0] checksum_acc_reg, checksum_acc_next;
    logic [7:0] bytes_remaining_reg, bytes_remaining_next;
    logic       frame_open_reg, frame_open_next;

    // classify the item and update the frame state
    always_comb
    begin
        logic [7:0] len_sat;
        logic [7:0] sum;
        logic [7:0] rem_dec;

        len_sat = (item.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                      : item.payload_length;
        rem_dec = bytes_remaining_reg - 8'd1;
        if (item.opcode == OP_START)
            sum = item.frame_type + len_sat;
        else
            sum = checksum_acc_reg + item.payload_byte;

        checksum_acc_next    = checksum_acc_reg;
        bytes_remaining_next = bytes_remaining_reg;
        frame_open_next      = frame_open_reg;
        job_push             = 1'b0;

        job.first_step   = STEP_HEAD;
        job.length       = len_sat;
        job.frame_type   = item.frame_type;
        job.command_code = item.command_code;
        job.data         = item.payload_byte;
        job.check        = sum ^ CHK_INVERT;
        job.close        = 1'b0;

        if (accept)
        begin
            if (item.opcode == OP_START)
            begin
                job_push = 1'b1;
                if (len_sat == 8'd0)
                begin
                    job.close            = 1'b1;
                    checksum_acc_next    = 8'd0;
                    bytes_remaining_next = 8'd0;
                    frame_open_next      = 1'b0;
                end
                else
                begin
                    checksum_acc_next    = sum;
                    bytes_remaining_next = len_sat;
                    frame_open_next      = 1'b1;
                end
            end
            else if (frame_open_reg)
            begin
                job_push       = 1'b1;
                job.first_step = STEP_DATA;
                if (rem_dec == 8'd0)
                begin
                    job.close            = 1'b1;
                    checksum_acc_next    = 8'd0;
                    bytes_remaining_next = 8'd0;
                    frame_open_next      = 1'b0;
                end
                else
                begin
                    checksum_acc_next    = sum;
                    bytes_remaining_next = rem_dec;
                end
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_acc_reg    <= '0;
            bytes_remaining_reg <= '0;
            frame_open_reg      <= 1'b0;
        end
        else
        begin
            checksum_acc_reg    <= checksum_acc_next;
            bytes_remaining_reg <= bytes_remaining_next;
            frame_open_reg      <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sfb_queue.sv]
`default_nettype none

module sfb_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire sfb_pkg::sfb_job_t wr_job,
    output logic                   full,
    input  wire logic              rd_en,
    output sfb_pkg::sfb_job_t      rd_job,
    output logic                   empty
);
    import sfb_pkg::*;

    sfb_job_t            store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full   = (count_reg == QCNT_W'(QDEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = store_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

[hw/rtl/sfb_back.sv]
`default_nettype none

module sfb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_avail,
    input  wire sfb_pkg::sfb_job_t job,
    output logic                   job_take,
    output logic                   empty,
    input  wire logic              pop,
    output sfb_pkg::sfb_out_t      result
);
    import sfb_pkg::*;

    sfb_job_t          job_reg;
    logic              job_valid_reg, job_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    sfb_out_t          out_reg;
    logic              out_valid_reg, out_valid_next;
    sfb_out_t          cur_out;
    logic              advance;
    logic              finishing;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // byte for the current step
    always_comb
    begin
        cur_out.out_byte    = HEAD_BYTE;
        cur_out.last_of_run = 1'b0;
        cur_out.frame_end   = 1'b0;
        case (step_reg)
            STEP_HEAD: cur_out.out_byte = HEAD_BYTE;
            STEP_LEN:  cur_out.out_byte = job_reg.length;
            STEP_TYPE: cur_out.out_byte = job_reg.frame_type;
            STEP_CMD:  cur_out.out_byte = job_reg.command_code;
            STEP_DATA: cur_out.out_byte = job_reg.data;
            STEP_CHK:  cur_out.out_byte = job_reg.check;
            STEP_REAR: cur_out.out_byte = REAR_BYTE;
            default:   cur_out.out_byte = HEAD_BYTE;
        endcase
        if (step_reg inside {STEP_CMD, STEP_DATA})
            cur_out.last_of_run = !job_reg.close;
        else if (step_reg == STEP_REAR)
        begin
            cur_out.last_of_run = 1'b1;
            cur_out.frame_end   = 1'b1;
        end
    end

    // sequencing and job hand-over
    always_comb
    begin
        advance   = job_valid_reg && (!out_valid_reg || pop);
        finishing = advance && cur_out.last_of_run;
        job_take  = job_avail && (!job_valid_reg || finishing);

        job_valid_next = job_valid_reg;
        if (job_take)
            job_valid_next = 1'b1;
        else if (finishing)
            job_valid_next = 1'b0;

        step_next = step_reg;
        if (job_take)
            step_next = job.first_step;
        else if (advance)
        begin
            case (step_reg)
                STEP_HEAD: step_next = STEP_LEN;
                STEP_LEN:  step_next = STEP_TYPE;
                STEP_TYPE: step_next = STEP_CMD;
                STEP_CMD:  step_next = STEP_CHK;
                STEP_DATA: step_next = STEP_CHK;
                STEP_CHK:  step_next = STEP_REAR;
                default:   step_next = STEP_HEAD;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job and result holding registers
    always_ff @(posedge clk)
    begin
        if (job_take)
            job_reg <= job;
        if (advance)
            out_reg <= cur_out;
    end

endmodule

`default_nettype wire

[hw/rtl/serial_frame_builder.sv]
`default_nettype none

// Serial frame builder: turns start and payload items into a framed byte stream.
// Input side is a queue write port: an item is taken at a clock edge with push
// high and full low. Opcode 0 opens a frame (head, length, type, command),
// opcode 1 carries one payload byte; a payload item with no open frame is dropped.
// Output side is a queue read port: while empty is low, result holds the oldest
// byte, and it is taken at an edge with pop high.
// Classification and checksum updates happen in the cycle an item is taken; the
// classified item then waits in a four-entry job queue, and while the output
// register is empty or popped the back end emits one byte per cycle into it.
// The first byte of an item passes through the job queue, the job register and
// the output register before it is on result. Throughput: one byte per cycle at
// the output while that register is empty or popped; an item yields 1, 3, 4 or 6
// bytes, and the job queue lets items be taken back to back while bursts drain.
// When pop stays low the output byte holds, the back end stops, and once the job
// queue holds four items full rises and input stops.
// Reset clears the frame state, the job queue and the output valid flag: no frame
// is open and empty is high.

module serial_frame_builder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire sfb_pkg::sfb_in_t item,
    output logic                  empty,
    input  wire logic             pop,
    output sfb_pkg::sfb_out_t     result
);
    import sfb_pkg::*;

    logic     accept;
    logic     job_push;
    sfb_job_t front_job;
    logic     q_full;
    logic     q_empty;
    sfb_job_t q_job;
    logic     job_take;

    assign accept = push && !q_full;
    assign full   = q_full;

    // front end: classify and keep frame state
    sfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (front_job)
    );

    // job queue between front and back
    sfb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (front_job),
        .full   (q_full),
        .rd_en  (job_take),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    // back end: byte sequencer and output register
    sfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (q_job),
        .job_take  (job_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // rear byte always closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |-> result.last_of_run)
        else $error("frame end without last_of_run");

    // rear byte value
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |-> (result.out_byte == REAR_BYTE))
        else $error("frame end byte is not the rear byte");

    // no job written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed while queue full");

    // back end never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> !q_empty)
        else $error("job taken from empty queue");

endmodule

`default_nettype wire

[verif/tb_serial_frame_builder.sv]
module tb_serial_frame_builder;

    import sfb_pkg::*;

    // what a row knows of its results: typed in by hand, or left to the predictor
    typedef struct packed {
        logic                typed;
        logic [2:0]          n;
        sfb_out_t [5:0]      res;
    } known_t;

    // one item waiting to be offered, with any hand-typed results
    typedef struct packed {
        sfb_in_t item;
        known_t  known;
    } frame_row_t;

    localparam int       NUM_ROWS   = 22;
    localparam int       RAND_ITEMS = 185;
    localparam int       HOLD_LEN   = 60;
    localparam int       QUIET_MAX  = 3000;
    localparam int       DRAIN_WAIT = 20;
    localparam sfb_out_t NO_BYTE    = '0;

    logic     clk    = 1'b0;
    logic     rst_n  = 1'b0;
    logic     push   = 1'b0;
    logic     pop    = 1'b0;
    sfb_in_t  in_item = '0;
    logic     full;
    logic     empty;
    sfb_out_t out_item;

    // predictor state
    logic [7:0] run_sum       = '0;
    logic [7:0] left_to_come  = '0;
    logic       frame_is_open = 1'b0;

    frame_row_t frame_table [NUM_ROWS];
    frame_row_t items_to_send [$];
    sfb_out_t   bytes_due [$];

    int send_idle    = 29;
    int recv_idle    = 61;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int accepted_cnt = 0;
    int bad_count    = 0;
    int quiet_cycles = 0;

    serial_frame_builder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (in_item),
        .empty  (empty),
        .pop    (pop),
        .result (out_item)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sfb_out_t ob(input logic [7:0] b, input logic l, input logic e);
        sfb_out_t o;
        o.out_byte    = b;
        o.last_of_run = l;
        o.frame_end   = e;
        return o;
    endfunction

    function automatic sfb_in_t start_it(input logic [7:0] t, input logic [7:0] c,
                                         input logic [7:0] len, input logic [7:0] junk);
        sfb_in_t it;
        it.opcode         = OP_START;
        it.frame_type     = t;
        it.command_code   = c;
        it.payload_length = len;
        it.payload_byte   = junk;
        return it;
    endfunction

    function automatic sfb_in_t data_it(input logic [7:0] b, input logic [7:0] t,
                                        input logic [7:0] c, input logic [7:0] len);
        sfb_in_t it;
        it.opcode         = OP_PAYLOAD;
        it.frame_type     = t;
        it.command_code   = c;
        it.payload_length = len;
        it.payload_byte   = b;
        return it;
    endfunction

    function automatic known_t listed(input int n, input sfb_out_t r0, input sfb_out_t r1,
                                      input sfb_out_t r2, input sfb_out_t r3,
                                      input sfb_out_t r4, input sfb_out_t r5);
        known_t k;
        k.typed  = 1'b1;
        k.n      = 3'(n);
        k.res[0] = r0;
        k.res[1] = r1;
        k.res[2] = r2;
        k.res[3] = r3;
        k.res[4] = r4;
        k.res[5] = r5;
        return k;
    endfunction

    function automatic frame_row_t row(input sfb_in_t it, input known_t k);
        frame_row_t r;
        r.item  = it;
        r.known = k;
        return r;
    endfunction

    // serialise one item into its frame bytes and advance the frame state
    function automatic known_t frame_bytes(input sfb_in_t it);
        known_t     k;
        logic [7:0] len;
        k = '0;
        if (it.opcode == OP_START)
        begin
            len = (it.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : it.payload_length;
            run_sum       = it.frame_type + len;
            left_to_come  = len;
            frame_is_open = 1'b1;
            k.res[0] = ob(HEAD_BYTE, 1'b0, 1'b0);
            k.res[1] = ob(len, 1'b0, 1'b0);
            k.res[2] = ob(it.frame_type, 1'b0, 1'b0);
            if (len == 8'd0)
            begin
                // empty frame closes at once
                k.res[3] = ob(it.command_code, 1'b0, 1'b0);
                k.res[4] = ob(run_sum ^ CHK_INVERT, 1'b0, 1'b0);
                k.res[5] = ob(REAR_BYTE, 1'b1, 1'b1);
                k.n = 3'd6;
                frame_is_open = 1'b0;
                run_sum       = '0;
            end
            else
            begin
                k.res[3] = ob(it.command_code, 1'b1, 1'b0);
                k.n = 3'd4;
            end
        end
        else if (frame_is_open)
        begin
            run_sum = run_sum + it.payload_byte;
            if (left_to_come != 8'd0)
                left_to_come = left_to_come - 8'd1;
            if (left_to_come == 8'd0)
            begin
                k.res[0] = ob(it.payload_byte, 1'b0, 1'b0);
                k.res[1] = ob(run_sum ^ CHK_INVERT, 1'b0, 1'b0);
                k.res[2] = ob(REAR_BYTE, 1'b1, 1'b1);
                k.n = 3'd3;
                frame_is_open = 1'b0;
                run_sum       = '0;
            end
            else
            begin
                k.res[0] = ob(it.payload_byte, 1'b1, 1'b0);
                k.n = 3'd1;
            end
        end
        return k;
    endfunction

    task automatic flag_bad(input string what, input int e, input int a);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, e, a);
    endtask

    // sender: offer the queued items, hold an item while full is high
    always @(posedge clk)
    begin : sender
        known_t k;
        logic   nxt;
        if (push && !full)
        begin
            k = frame_bytes(in_item);
            if (items_to_send[0].known.typed)
                k = items_to_send[0].known;
            for (int j = 0; j < int'(k.n); j++)
                bytes_due.push_back(k.res[j]);
            void'(items_to_send.pop_front());
            accepted_cnt++;
        end
        if (!rst_n || items_to_send.size() == 0)
            nxt = 1'b0;
        else if (push && full)
            nxt = 1'b1;
        else
            nxt = ($urandom_range(0, 99) >= send_idle);
        push <= nxt;
        if (nxt)
            in_item <= items_to_send[0].item;
    end

    // receiver: random idling, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN - 1;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        sfb_out_t w;
        if (pop && !empty)
        begin
            if (bytes_due.size() == 0)
                flag_bad("unexpected item, out_byte", -1, int'(out_item.out_byte));
            else
            begin
                w = bytes_due.pop_front();
                if (out_item.out_byte !== w.out_byte)
                    flag_bad("out_byte", int'(w.out_byte), int'(out_item.out_byte));
                if (out_item.last_of_run !== w.last_of_run)
                    flag_bad("last_of_run", int'(w.last_of_run),
                             int'(out_item.last_of_run));
                if (out_item.frame_end !== w.frame_end)
                    flag_bad("frame_end", int'(w.frame_end), int'(out_item.frame_end));
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // directed table, random frames, phases and end of run
    initial
    begin
        int   pick;
        int   len;
        int   cut;
        int   counted;
        int   total;
        logic gen_open;

        // no open frame, empty frames at both extremes, a one-byte frame
        frame_table[0]  = row(data_it(8'h5A, 8'h00, 8'h00, 8'h00),
                              listed(0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
        frame_table[1]  = row(start_it(8'h00, 8'h00, 8'h00, 8'hFF),
                              listed(6, ob(HEAD_BYTE, 1'b0, 1'b0), ob(8'h00, 1'b0, 1'b0),
                                     ob(8'h00, 1'b0, 1'b0), ob(8'h00, 1'b0, 1'b0),
                                     ob(8'hFF, 1'b0, 1'b0), ob(REAR_BYTE, 1'b1, 1'b1)));
        frame_table[2]  = row(start_it(8'hFF, 8'hFF, 8'h00, 8'h00),
                              listed(6, ob(HEAD_BYTE, 1'b0, 1'b0), ob(8'h00, 1'b0, 1'b0),
                                     ob(8'hFF, 1'b0, 1'b0), ob(8'hFF, 1'b0, 1'b0),
                                     ob(8'h00, 1'b0, 1'b0), ob(REAR_BYTE, 1'b1, 1'b1)));
        frame_table[3]  = row(start_it(8'h12, 8'h34, 8'h01, 8'h00),
                              listed(4, ob(HEAD_BYTE, 1'b0, 1'b0), ob(8'h01, 1'b0, 1'b0),
                                     ob(8'h12, 1'b0, 1'b0), ob(8'h34, 1'b1, 1'b0),
                                     NO_BYTE, NO_BYTE));
        frame_table[4]  = row(data_it(8'h56, 8'h00, 8'h00, 8'h00),
                              listed(3, ob(8'h56, 1'b0, 1'b0), ob(8'h96, 1'b0, 1'b0),
                                     ob(REAR_BYTE, 1'b1, 1'b1), NO_BYTE, NO_BYTE, NO_BYTE));
        frame_table[5]  = row(data_it(8'h77, 8'hFF, 8'hFF, 8'hFF),
                              listed(0, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE));
        // length above the limit is saturated
        frame_table[6]  = row(start_it(8'h00, 8'hA5, 8'hFF, 8'h00),
                              listed(4, ob(HEAD_BYTE, 1'b0, 1'b0), ob(MAX_PAYLOAD, 1'b0, 1'b0),
                                     ob(8'h00, 1'b0, 1'b0), ob(8'hA5, 1'b1, 1'b0),
                                     NO_BYTE, NO_BYTE));
        frame_table[7]  = row(data_it(8'hFF, 8'h00, 8'h00, 8'h00), '0);
        // new start abandons the open frame
        frame_table[8]  = row(start_it(8'hFF, 8'h00, 8'h02, 8'h00), '0);
        frame_table[9]  = row(data_it(8'hFF, 8'h00, 8'h00, 8'h00), '0);
        frame_table[10] = row(data_it(8'h00, 8'h00, 8'h00, 8'h00), '0);
        frame_table[11] = row(start_it(8'h80, 8'h7F, 8'hFB, 8'h00),
                              listed(4, ob(HEAD_BYTE, 1'b0, 1'b0), ob(MAX_PAYLOAD, 1'b0, 1'b0),
                                     ob(8'h80, 1'b0, 1'b0), ob(8'h7F, 1'b1, 1'b0),
                                     NO_BYTE, NO_BYTE));
        frame_table[12] = row(data_it(8'h01, 8'h00, 8'h00, 8'h00), '0);
        frame_table[13] = row(start_it(8'hAA, 8'h55, MAX_PAYLOAD, 8'h00), '0);
        // fields not used by the opcode carry junk
        frame_table[14] = row(start_it(8'h01, 8'h02, 8'h03, 8'hFF), '0);
        frame_table[15] = row(data_it(8'h00, 8'hFF, 8'hFF, 8'hFF), '0);
        frame_table[16] = row(data_it(8'h80, 8'h55, 8'hAA, 8'h01), '0);
        frame_table[17] = row(data_it(8'h7F, 8'hAA, 8'h55, 8'hFE), '0);
        // checksum wraps past 8 bits
        frame_table[18] = row(start_it(8'hFE, 8'h01, 8'h01, 8'h00), '0);
        frame_table[19] = row(data_it(8'hFF, 8'h00, 8'h00, 8'h00), '0);
        frame_table[20] = row(start_it(8'hFF, 8'hFF, 8'hFF, 8'hFF), '0);
        frame_table[21] = row(start_it(8'h00, 8'h00, 8'h00, 8'h00), '0);

        for (int i = 0; i < NUM_ROWS; i++)
            items_to_send.push_back(frame_table[i]);

        // random frames, mostly well formed, some cut short, some stray payload
        counted  = 0;
        gen_open = 1'b0;
        while (counted < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                items_to_send.push_back(row(data_it(8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255))), '0));
                if (gen_open)
                    counted++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(0, 6);
                else if (pick < 90)
                    len = $urandom_range(7, 24);
                else if (pick < 97)
                    len = $urandom_range(250, 255);
                else
                    len = $urandom_range(128, 249);
                items_to_send.push_back(row(start_it(8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'(len), 8'($urandom_range(0, 255))), '0));
                counted++;
                if (len > 24)
                    cut = $urandom_range(0, 6);
                else if (len > 0 && $urandom_range(0, 99) < 15)
                    cut = $urandom_range(0, len - 1);
                else
                    cut = len;
                for (int j = 0; j < cut; j++)
                begin
                    items_to_send.push_back(row(data_it(8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255))), '0));
                    counted++;
                end
                gen_open = (cut < len);
            end
        end
        total = items_to_send.size();

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // second phase: swap idling, with a long hold-off on the receiver
        while (accepted_cnt < total / 3)
            @(negedge clk);
        send_idle = 61;
        recv_idle = 29;
        hold_asks++;

        // third phase: no idling, the hold-off fills the block
        while (accepted_cnt < (2 * total) / 3)
            @(negedge clk);
        send_idle = 0;
        recv_idle = 0;
        hold_asks++;

        // drain
        while (items_to_send.size() != 0)
            @(negedge clk);
        while (bytes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (bytes_due.size() != 0)
            bad_count++;

        if (bad_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[serial_frame_builder.f]
hw/rtl/sfb_pkg.sv
hw/rtl/sfb_front.sv
hw/rtl/sfb_queue.sv
hw/rtl/sfb_back.sv
hw/rtl/serial_frame_builder.sv
verif/tb_serial_frame_builder.sv
